// ===== src/bmls_pkg.sv =====
// Shared types and constants for the byte-addressable load/store memory.
// Used by byte_memory_load_store.
package bmls_pkg;

  localparam logic       CMD_READ  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;

  localparam logic [1:0] WIDTH_BYTE = 2'd0;
  localparam logic [1:0] WIDTH_HALF = 2'd1;
  localparam logic [1:0] WIDTH_WORD = 2'd2;

  localparam int         SIZE_W     = 17;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd65536;
  localparam logic [7:0] FILL_BYTE  = 8'ha5;
  localparam int         LANES      = 4;

  typedef logic [SIZE_W-1:0] size_t;

  // Number of bytes touched; the unused width code behaves as a word.
  function automatic logic [2:0] width_bytes(input logic [1:0] code);
    logic [2:0] n;
    case (code)
      WIDTH_BYTE: n = 3'd1;
      WIDTH_HALF: n = 3'd2;
      default:    n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

// ===== src/bmls_chan_if.sv =====
// Valid/ready channel interfaces for the load/store memory.
// Request and response channels; payload widths are fixed in each interface.
interface bmls_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  access_width;
  logic        sign_extend;
  logic [31:0] address;
  logic [31:0] write_data;

  modport source (output valid, command, access_width, sign_extend, address, write_data,
                  input ready);
  modport sink   (input valid, command, access_width, sign_extend, address, write_data,
                  output ready);
endinterface

interface bmls_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [3:0]  illegal_mask;
  logic        any_illegal;

  modport source (output valid, read_data, illegal_mask, any_illegal, input ready);
  modport sink   (input valid, read_data, illegal_mask, any_illegal, output ready);
endinterface

// ===== src/bmls_ram.sv =====
// Generic single-port RAM with registered read data.
// Read data holds until the next enabled read. No package dependency.
module bmls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== src/byte_memory_load_store.sv =====
// Top level of the byte-addressable little-endian load/store memory.
// Depends on bmls_pkg, bmls_chan_if.sv and bmls_ram.
//
// Usage:
//   req  : one transaction per access (command, access_width, sign_extend,
//          address, write_data). Accepted when valid and ready are both high.
//   rsp  : exactly one transaction per request (read_data, illegal_mask,
//          any_illegal), in request order.
//   cfg  : cfg_write_en/cfg_write_data set the usable size; the size is rounded
//          up to a multiple of 16 and limited to MEM_BYTES. Write it only while
//          no request is in flight.
// Timing: an accepted request goes through the bank read (with stage 1), then the
//   output register, from which its response is shown on rsp; a stall can hold it
//   in stage 1. One request per cycle is sustained while rsp.ready is high; four
//   byte-wide banks (one per address low bits) serve any unaligned access whole.
// Reset: every byte returns to 0xa5 by a fill pass that writes one row of all
//   four banks per cycle, with req.ready low; the size register resets to 65536
//   (limited to MEM_BYTES) at once, and cfg writes go on during the fill.
// Stall: when rsp.ready is low while a response waits, the output register holds,
//   the bank read data holds, and req.ready drops so nothing is lost.
module byte_memory_load_store #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [bmls_pkg::SIZE_W-1:0] cfg_write_data,
  bmls_req_if.sink                    req,
  bmls_rsp_if.source                  rsp
);

  localparam int LANES = bmls_pkg::LANES;
  localparam int DEPTH = (MEM_BYTES + LANES - 1) / LANES;
  localparam int ROW_W = $clog2(DEPTH);
  localparam int LIM_W = $clog2(MEM_BYTES + 1);

  // Round the requested size up to 16 bytes and saturate at MEM_BYTES.
  function automatic logic [LIM_W-1:0] usable_limit(input bmls_pkg::size_t size);
    logic [bmls_pkg::SIZE_W:0] sum;
    logic [31:0]               rounded;
    sum     = {1'b0, size} + (bmls_pkg::SIZE_W+1)'(15);
    rounded = 32'({sum[bmls_pkg::SIZE_W:4], 4'b0000});
    if (rounded > 32'(MEM_BYTES)) begin
      return LIM_W'(MEM_BYTES);
    end
    return LIM_W'(rounded);
  endfunction

  // Usable size limit, held already rounded.
  logic [LIM_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= usable_limit(bmls_pkg::SIZE_RESET);
    end else if (cfg_write_en) begin
      limit <= usable_limit(cfg_write_data);
    end
  end

  // Fill pass after reset.
  logic             clearing;
  logic [ROW_W-1:0] clear_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_row <= '0;
    end else if (clearing) begin
      clear_row <= clear_row + ROW_W'(1);
      if (clear_row == ROW_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Handshake: stage 1 advances when the output register is free or drained.
  logic s1_valid;
  logic out_valid;
  logic s1_adv;
  logic accept;

  assign s1_adv    = !out_valid || rsp.ready;
  assign req.ready = !clearing && s1_adv;
  assign accept    = req.valid && req.ready;

  // Per-bank decode: bank b serves byte (b - address[1:0]) of the access.
  logic [2:0]       nbytes;
  logic [1:0]       lane_idx [LANES];
  logic [31:0]      lane_addr [LANES];
  logic [LANES-1:0] lane_active;
  logic [LANES-1:0] lane_legal;
  logic [LANES-1:0] bank_en;
  logic             bank_we;
  logic [ROW_W-1:0] bank_row [LANES];
  logic [7:0]       bank_wdata [LANES];
  logic [7:0]       bank_rdata [LANES];

  assign nbytes  = bmls_pkg::width_bytes(req.access_width);
  assign bank_we = clearing || (req.command == bmls_pkg::CMD_WRITE);

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      lane_idx[b]    = 2'(b) - req.address[1:0];
      lane_addr[b]   = req.address + 32'(lane_idx[b]);
      lane_active[b] = {1'b0, lane_idx[b]} < nbytes;
      lane_legal[b]  = lane_addr[b] < 32'(limit);
      if (clearing) begin
        bank_en[b]    = 1'b1;
        bank_row[b]   = clear_row;
        bank_wdata[b] = bmls_pkg::FILL_BYTE;
      end else begin
        bank_en[b]    = accept && lane_active[b] && lane_legal[b];
        bank_row[b]   = lane_addr[b][ROW_W+1:2];
        bank_wdata[b] = req.write_data[8*lane_idx[b] +: 8];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    bmls_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
    ) u_bank (
      .clk   (clk),
      .en    (bank_en[g]),
      .we    (bank_we),
      .addr  (bank_row[g]),
      .wdata (bank_wdata[g]),
      .rdata (bank_rdata[g])
    );
  end

  // Illegal mask in access byte order.
  logic [3:0] mask_in;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mask_in[i] = (3'(i) < nbytes) && !lane_legal[2'(i) + req.address[1:0]];
    end
  end

  // Stage 1: metadata alongside the bank read.
  logic       s1_write;
  logic [2:0] s1_nbytes;
  logic       s1_sx;
  logic [1:0] s1_lo;
  logic [3:0] s1_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_write  <= (req.command == bmls_pkg::CMD_WRITE);
      s1_nbytes <= nbytes;
      s1_sx     <= req.sign_extend;
      s1_lo     <= req.address[1:0];
      s1_mask   <= mask_in;
    end
  end

  // Assemble the little-endian read value, sign-extended on request; illegal bytes count as zero, writes return zero.
  logic [31:0] value;

  always_comb begin
    value = '0;
    for (int i = 0; i < LANES; i++) begin
      if ((3'(i) < s1_nbytes) && !s1_mask[i]) begin
        value[8*i +: 8] = bank_rdata[2'(i) + s1_lo];
      end
    end
    if (s1_write) begin
      value = '0;
    end else if (s1_sx) begin
      if (s1_nbytes == 3'd1 && value[7]) begin
        value[31:8] = '1;
      end else if (s1_nbytes == 3'd2 && value[15]) begin
        value[31:16] = '1;
      end
    end
  end

  // Output register.
  logic [31:0] read_data;
  logic [3:0]  illegal_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      read_data    <= value;
      illegal_mask <= s1_mask;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = read_data;
  assign rsp.illegal_mask = illegal_mask;
  assign rsp.any_illegal  = |illegal_mask;

endmodule
